### rtl/vpw_pkg.sv
// Package with the types and constants shared by the vertex position welder.
package vpw_pkg;

    localparam int unsigned TABLE_SLOTS_DEF = 4096;
    localparam int unsigned COORD_FRAC_BITS_DEF = 16;
    localparam int unsigned RECIP_FRAC_BITS = 16;
    localparam logic [31:0] CELL_RECIP_RESET = 32'h0001_0000;
    localparam int unsigned EPOCH_W = 8;

    localparam logic [31:0] MIX_X = 32'h9E37_79B1;
    localparam logic [31:0] MIX_Y = 32'h85EB_CA77;
    localparam logic [31:0] MIX_Z = 32'hC2B2_AE3D;
    localparam logic [31:0] MIX_F = 32'h2C1B_3C6D;

    typedef struct packed {
        logic        mesh_start;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
    } in_item_t;

    typedef struct packed {
        logic [11:0] vertex_index;
        logic        is_new;
        logic        table_full;
        logic [12:0] unique_count;
    } out_item_t;

    typedef struct packed {
        logic        mesh_start;
        logic [31:0] key_x;
        logic [31:0] key_y;
        logic [31:0] key_z;
    } job_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_QUANT,
        F_HASH1,
        F_HASH2,
        F_MOD,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_READ,
        B_CHECK
    } back_state_t;

endpackage

### rtl/vpw_front.sv
// Front end: accepts positions, quantizes them to cell keys and hashes the keys.
module vpw_front #(
    parameter int unsigned TABLE_SLOTS = vpw_pkg::TABLE_SLOTS_DEF,
    parameter int unsigned COORD_FRAC_BITS = vpw_pkg::COORD_FRAC_BITS_DEF,
    localparam int unsigned IDX_W = $clog2(TABLE_SLOTS)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  vpw_pkg::in_item_t  s_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        cfg_data,
    input  logic               clearing,
    output logic               q_valid,
    input  logic               q_ready,
    output vpw_pkg::job_t      q_job,
    output logic [IDX_W-1:0]   q_slot
);

    localparam int unsigned SH = COORD_FRAC_BITS + vpw_pkg::RECIP_FRAC_BITS;
    localparam bit SLOTS_POW2 = (TABLE_SLOTS == (1 << IDX_W));
    localparam logic [31:0] RECIP_SLOTS = 32'((64'd1 << 32) / 64'(TABLE_SLOTS));

    vpw_pkg::front_state_t state_reg, state_next;
    logic [31:0]       recip_reg;
    vpw_pkg::in_item_t item_reg;
    logic [1:0]        cnt_reg, cnt_next;
    logic [63:0]       prod_reg;
    logic              neg_reg;
    logic [31:0]       key_reg [3];
    logic [31:0]       h_reg;
    logic [31:0]       m_reg;
    logic [31:0]       mod_reg;
    logic [31:0]       qest_reg;
    logic [1:0]        step_reg, step_next;

    logic [31:0] coord, mag, key_q, h2, hm;
    logic [64:0] rsum, rq;

    assign cfg_ready = 1'b1;

    always_comb begin
        unique case (cnt_reg)
            2'd0:    coord = item_reg.pos_x;
            2'd1:    coord = item_reg.pos_y;
            default: coord = item_reg.pos_z;
        endcase
        mag = coord[31] ? (~coord + 32'd1) : coord;
        rsum = {1'b0, prod_reg} + (65'd1 << (SH - 1));
        rq = rsum >> SH;
        if (neg_reg) begin
            key_q = (rq >= 65'h8000_0000) ? 32'h8000_0000 : (~rq[31:0] + 32'd1);
        end else begin
            key_q = (rq > 65'h7FFF_FFFF) ? 32'h7FFF_FFFF : rq[31:0];
        end
        h2 = h_reg ^ (h_reg >> 15);
        hm = m_reg ^ (m_reg >> 13);
    end

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        step_next = step_reg;
        s_ready = 1'b0;
        q_valid = 1'b0;
        unique case (state_reg)
            vpw_pkg::F_IDLE: begin
                s_ready = !clearing;
                if (s_valid && !clearing) begin
                    state_next = vpw_pkg::F_QUANT;
                    cnt_next = 2'd0;
                end
            end
            vpw_pkg::F_QUANT: begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3) begin
                    state_next = vpw_pkg::F_HASH1;
                end
            end
            vpw_pkg::F_HASH1: state_next = vpw_pkg::F_HASH2;
            vpw_pkg::F_HASH2: begin
                state_next = vpw_pkg::F_MOD;
                step_next = 2'd2;
            end
            vpw_pkg::F_MOD: begin
                if (SLOTS_POW2) begin
                    state_next = vpw_pkg::F_PUSH;
                end else begin
                    step_next = step_reg - 2'd1;
                    if (step_reg == 2'd0) begin
                        state_next = vpw_pkg::F_PUSH;
                    end
                end
            end
            vpw_pkg::F_PUSH: begin
                q_valid = 1'b1;
                if (q_ready) begin
                    state_next = vpw_pkg::F_IDLE;
                end
            end
            default: state_next = vpw_pkg::F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vpw_pkg::F_IDLE;
            recip_reg <= vpw_pkg::CELL_RECIP_RESET;
            cnt_reg <= 2'd0;
            step_reg <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            step_reg <= step_next;
            if (cfg_valid) begin
                recip_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == vpw_pkg::F_IDLE && s_valid && !clearing) begin
            item_reg <= s_data;
        end
        if (state_reg == vpw_pkg::F_QUANT) begin
            prod_reg <= 64'(mag) * 64'(recip_reg);
            neg_reg <= coord[31];
            if (cnt_reg != 2'd0) begin
                key_reg[cnt_reg - 2'd1] <= key_q;
            end
        end
        if (state_reg == vpw_pkg::F_HASH1) begin
            h_reg <= 32'(key_reg[0] * vpw_pkg::MIX_X) ^ 32'(key_reg[1] * vpw_pkg::MIX_Y)
                   ^ 32'(key_reg[2] * vpw_pkg::MIX_Z);
        end
        if (state_reg == vpw_pkg::F_HASH2) begin
            m_reg <= 32'(h2 * vpw_pkg::MIX_F);
        end
        if (state_reg == vpw_pkg::F_HASH2) begin
            mod_reg <= '0;
        end else if (state_reg == vpw_pkg::F_MOD) begin
            if (SLOTS_POW2) begin
                mod_reg <= 32'(hm[IDX_W-1:0]);
            end else if (step_reg == 2'd2) begin
                mod_reg <= hm;
                qest_reg <= 32'((64'(hm) * 64'(RECIP_SLOTS)) >> 32);
            end else if (step_reg == 2'd1) begin
                mod_reg <= mod_reg - 32'(64'(qest_reg) * 64'(TABLE_SLOTS));
            end else if (mod_reg >= 32'(TABLE_SLOTS)) begin
                mod_reg <= mod_reg - 32'(TABLE_SLOTS);
            end
        end
    end

    assign q_job.mesh_start = item_reg.mesh_start;
    assign q_job.key_x = key_reg[0];
    assign q_job.key_y = key_reg[1];
    assign q_job.key_z = key_reg[2];
    assign q_slot = mod_reg[IDX_W-1:0];

endmodule

### rtl/vpw_queue.sv
// Two-entry queue between the front end and the table walker.
module vpw_queue #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] buf_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             push, pop;

    assign in_ready = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data = buf_reg[rd_ptr_reg];
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

### rtl/vpw_back.sv
// Table walker: probes the hash table, inserts new cells and drives the result register.
module vpw_back #(
    parameter int unsigned TABLE_SLOTS = vpw_pkg::TABLE_SLOTS_DEF,
    localparam int unsigned IDX_W = $clog2(TABLE_SLOTS),
    localparam int unsigned CNT_W = $clog2(TABLE_SLOTS + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    output logic               q_ready,
    input  vpw_pkg::job_t      q_job,
    input  logic [IDX_W-1:0]   q_slot,
    output logic               clearing,
    output logic               m_valid,
    input  logic               m_ready,
    output vpw_pkg::out_item_t m_data
);

    localparam int unsigned EW = vpw_pkg::EPOCH_W;
    localparam int unsigned ENT_W = EW + 96 + IDX_W;
    localparam logic [EW-1:0] EPOCH_MAX = '1;

    vpw_pkg::back_state_t state_reg, state_next;
    logic [ENT_W-1:0]   mem [TABLE_SLOTS];
    logic [ENT_W-1:0]   rd_reg;
    vpw_pkg::job_t      job_reg;
    logic [IDX_W-1:0]   slot_reg, slot_next;
    logic [IDX_W-1:0]   probe_reg, probe_next;
    logic [IDX_W-1:0]   clr_reg, clr_next;
    logic               resume_reg, resume_next;
    logic [EW-1:0]      epoch_reg, epoch_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               out_valid_reg, out_valid_next;
    vpw_pkg::out_item_t out_reg, out_next;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENT_W-1:0]   wr_data;
    logic               out_free, hit_valid, hit_key;
    logic [EW-1:0]      rd_epoch;
    logic [95:0]        rd_key;
    logic [IDX_W-1:0]   rd_vertex;

    assign rd_epoch = rd_reg[ENT_W-1 -: EW];
    assign rd_key = rd_reg[IDX_W +: 96];
    assign rd_vertex = rd_reg[IDX_W-1:0];
    assign hit_valid = (rd_epoch == epoch_reg);
    assign hit_key = (rd_key == {job_reg.key_x, job_reg.key_y, job_reg.key_z});
    assign out_free = !out_valid_reg || m_ready;
    assign clearing = (state_reg == vpw_pkg::B_CLEAR);
    assign m_valid = out_valid_reg;
    assign m_data = out_reg;

    always_comb begin
        state_next = state_reg;
        slot_next = slot_reg;
        probe_next = probe_reg;
        clr_next = clr_reg;
        resume_next = resume_reg;
        epoch_next = epoch_reg;
        count_next = count_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next = out_reg;
        q_ready = 1'b0;
        wr_en = 1'b0;
        wr_addr = slot_reg;
        wr_data = {epoch_reg, job_reg.key_x, job_reg.key_y, job_reg.key_z,
                   count_reg[IDX_W-1:0]};
        unique case (state_reg)
            vpw_pkg::B_CLEAR: begin
                wr_en = 1'b1;
                wr_addr = clr_reg;
                wr_data = '0;
                clr_next = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_W'(TABLE_SLOTS - 1)) begin
                    clr_next = '0;
                    epoch_next = EW'(1);
                    state_next = resume_reg ? vpw_pkg::B_READ : vpw_pkg::B_IDLE;
                    resume_next = 1'b0;
                end
            end
            vpw_pkg::B_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    slot_next = q_slot;
                    probe_next = '0;
                    state_next = vpw_pkg::B_READ;
                    if (q_job.mesh_start) begin
                        count_next = '0;
                        if (epoch_reg == EPOCH_MAX) begin
                            state_next = vpw_pkg::B_CLEAR;
                            resume_next = 1'b1;
                        end else begin
                            epoch_next = epoch_reg + EW'(1);
                        end
                    end
                end
            end
            vpw_pkg::B_READ: state_next = vpw_pkg::B_CHECK;
            vpw_pkg::B_CHECK: begin
                if (out_free) begin
                    if (!hit_valid) begin
                        wr_en = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        out_valid_next = 1'b1;
                        out_next.vertex_index = 12'(count_reg);
                        out_next.is_new = 1'b1;
                        out_next.table_full = 1'b0;
                        out_next.unique_count = 13'(count_reg + CNT_W'(1));
                        state_next = vpw_pkg::B_IDLE;
                    end else if (hit_key) begin
                        out_valid_next = 1'b1;
                        out_next.vertex_index = 12'(rd_vertex);
                        out_next.is_new = 1'b0;
                        out_next.table_full = 1'b0;
                        out_next.unique_count = 13'(count_reg);
                        state_next = vpw_pkg::B_IDLE;
                    end else if (probe_reg == IDX_W'(TABLE_SLOTS - 1)) begin
                        out_valid_next = 1'b1;
                        out_next.vertex_index = '0;
                        out_next.is_new = 1'b0;
                        out_next.table_full = 1'b1;
                        out_next.unique_count = 13'(count_reg);
                        state_next = vpw_pkg::B_IDLE;
                    end else begin
                        probe_next = probe_reg + IDX_W'(1);
                        slot_next = (slot_reg == IDX_W'(TABLE_SLOTS - 1)) ? '0
                                  : slot_reg + IDX_W'(1);
                        state_next = vpw_pkg::B_READ;
                    end
                end
            end
            default: state_next = vpw_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vpw_pkg::B_CLEAR;
            clr_reg <= '0;
            resume_reg <= 1'b0;
            epoch_reg <= '0;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            resume_reg <= resume_next;
            epoch_reg <= epoch_next;
            count_reg <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
        probe_reg <= probe_next;
        out_reg <= out_next;
        if (state_reg == vpw_pkg::B_IDLE && q_valid) begin
            job_reg <= q_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[slot_reg];
    end

endmodule

### rtl/vertex_position_welder.sv
// Top level of the vertex position welder: front end, queue and table walker.
//
// Usage: each item on the s_ channel carries a Q16.16 position and a mesh_start
// flag; each item yields one result on the m_ channel with the welded index,
// the new and full flags and the running unique count. The cfg_ channel writes
// the reciprocal cell size and is always ready; write it only while idle.
// The front end holds one item at a time and takes no new one until it has
// handed the last one on: it quantizes on one shared multiplier, runs two hash
// multiply stages, reduces the hash to a slot (by reciprocal multiply and fixup
// when the slot count is not a power of two) and hands the item on.
// The table walker reads and then checks one slot per probe.
// After reset the slot memory is swept and no item is accepted meanwhile; the
// same sweep runs at every 255th mesh start when the epoch tag wraps. A stalled
// receiver holds the result register, the walker then waits, the queue fills
// and the front end holds its item with s_ready low.
module vertex_position_welder #(
    parameter int unsigned TABLE_SLOTS = vpw_pkg::TABLE_SLOTS_DEF,
    parameter int unsigned COORD_FRAC_BITS = vpw_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  vpw_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output vpw_pkg::out_item_t m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        cfg_data
);

    localparam int unsigned IDX_W = $clog2(TABLE_SLOTS);
    localparam int unsigned QW = $bits(vpw_pkg::job_t) + IDX_W;

    logic                 clearing;
    logic                 fq_valid, fq_ready, qb_valid, qb_ready;
    vpw_pkg::job_t        f_job, b_job;
    logic [IDX_W-1:0]     f_slot, b_slot;
    logic [QW-1:0]        qb_data;

    vpw_front #(
        .TABLE_SLOTS(TABLE_SLOTS),
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .clearing(clearing),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_job(f_job), .q_slot(f_slot)
    );

    vpw_queue #(.WIDTH(QW)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(fq_valid), .in_ready(fq_ready), .in_data({f_job, f_slot}),
        .out_valid(qb_valid), .out_ready(qb_ready), .out_data(qb_data)
    );

    assign {b_job, b_slot} = qb_data;

    vpw_back #(.TABLE_SLOTS(TABLE_SLOTS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(qb_valid), .q_ready(qb_ready), .q_job(b_job), .q_slot(b_slot),
        .clearing(clearing),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

`ifndef SYNTH
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !s_ready)
        else $error("item accepted during table sweep");
    a_new_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_new |-> !m_data.table_full)
        else $error("result both new and full");
    a_full_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.table_full |-> m_data.vertex_index == 12'd0)
        else $error("full result with nonzero index");
`endif

endmodule

### bench/vertex_position_welder_test.sv
// Self-checking testbench for the vertex position welder: directed and random items.
module vertex_position_welder_test;

    localparam int unsigned SLOTS = vpw_pkg::TABLE_SLOTS_DEF;
    localparam longint unsigned LIMIT_CYCLES = 900000;

    class weld_scoreboard;
        logic [31:0] recip;
        logic [31:0] key_x[SLOTS];
        logic [31:0] key_y[SLOTS];
        logic [31:0] key_z[SLOTS];
        logic [11:0] vertex_of[SLOTS];
        bit          occupied[SLOTS];
        logic [12:0] next_vertex;
        vpw_pkg::out_item_t pending[$];
        int          failures;

        function new();
            recip = vpw_pkg::CELL_RECIP_RESET;
            next_vertex = 0;
            failures = 0;
            foreach (occupied[i]) occupied[i] = 0;
        endfunction

        function logic [31:0] cell_key(logic [31:0] coord);
            logic [63:0] mag;
            logic [63:0] prod;
            logic [63:0] q;
            bit          neg;
            neg = coord[31];
            mag = neg ? (64'h1_0000_0000 - {32'd0, coord}) : {32'd0, coord};
            prod = mag * {32'd0, recip};
            q = (prod + (64'd1 << (vpw_pkg::COORD_FRAC_BITS_DEF
                                   + vpw_pkg::RECIP_FRAC_BITS - 1)))
                >> (vpw_pkg::COORD_FRAC_BITS_DEF + vpw_pkg::RECIP_FRAC_BITS);
            if (neg) begin
                if (q >= 64'h8000_0000) return 32'h8000_0000;
                return 32'(64'h1_0000_0000 - q);
            end
            if (q > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
            return q[31:0];
        endfunction

        function int unsigned home_slot(logic [31:0] kx, logic [31:0] ky, logic [31:0] kz);
            logic [31:0] h;
            logic [63:0] p;
            h = kx * vpw_pkg::MIX_X;
            h ^= ky * vpw_pkg::MIX_Y;
            h ^= kz * vpw_pkg::MIX_Z;
            h ^= h >> 15;
            p = {32'd0, h} * {32'd0, vpw_pkg::MIX_F};
            h = p[31:0];
            h ^= h >> 13;
            return h % SLOTS;
        endfunction

        function void note_input(vpw_pkg::in_item_t it);
            logic [31:0] kx, ky, kz;
            int unsigned slot;
            vpw_pkg::out_item_t r;
            if (it.mesh_start) begin
                foreach (occupied[i]) occupied[i] = 0;
                next_vertex = 0;
            end
            kx = cell_key(it.pos_x);
            ky = cell_key(it.pos_y);
            kz = cell_key(it.pos_z);
            slot = home_slot(kx, ky, kz);
            r = '0;
            r.table_full = 1;
            for (int n = 0; n < SLOTS; n++) begin
                if (!occupied[slot]) begin
                    occupied[slot] = 1;
                    key_x[slot] = kx;
                    key_y[slot] = ky;
                    key_z[slot] = kz;
                    vertex_of[slot] = next_vertex[11:0];
                    r.vertex_index = next_vertex[11:0];
                    next_vertex++;
                    r.is_new = 1;
                    r.table_full = 0;
                    break;
                end
                if (key_x[slot] == kx && key_y[slot] == ky && key_z[slot] == kz) begin
                    r.vertex_index = vertex_of[slot];
                    r.table_full = 0;
                    break;
                end
                slot = (slot + 1) % SLOTS;
            end
            r.unique_count = next_vertex;
            pending = {pending, r};
        endfunction

        function void check_result(vpw_pkg::out_item_t got);
            vpw_pkg::out_item_t exp;
            if (pending.size() == 0) begin
                $error("result with no item outstanding: %h", got);
                failures++;
                return;
            end
            exp = pending.pop_front();
            if (got.vertex_index !== exp.vertex_index) begin
                $error("vertex_index expected %0d actual %0d", exp.vertex_index, got.vertex_index);
                failures++;
            end
            if (got.is_new !== exp.is_new) begin
                $error("is_new expected %0d actual %0d", exp.is_new, got.is_new);
                failures++;
            end
            if (got.table_full !== exp.table_full) begin
                $error("table_full expected %0d actual %0d", exp.table_full, got.table_full);
                failures++;
            end
            if (got.unique_count !== exp.unique_count) begin
                $error("unique_count expected %0d actual %0d", exp.unique_count,
                    got.unique_count);
                failures++;
            end
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    vpw_pkg::in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    vpw_pkg::out_item_t m_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [31:0] cfg_data;

    weld_scoreboard welds;
    int unsigned sender_idle_pct;
    int unsigned receiver_idle_pct;
    longint unsigned cycle_count;
    logic [31:0] near_points[$];

    vertex_position_welder i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        welds = new();
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            welds.check_result(m_data);
        end
        m_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= (aresetn === 1'b0) ? 0 : cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("vertex_position_welder verification failed");
            $finish;
        end
    end

    task automatic send_position(bit start, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        vpw_pkg::in_item_t it;
        it.mesh_start = start;
        it.pos_x = x;
        it.pos_y = y;
        it.pos_z = z;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        welds.note_input(it);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (welds.pending.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_recip(logic [31:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        welds.recip = value;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] random_coord();
        case ($urandom_range(4))
            0: return $urandom();
            1: return 32'($signed($urandom_range(2000)) - 1000) << 12;
            default: return 32'($signed($urandom_range(64)) - 32) << 16;
        endcase
    endfunction

    task automatic random_phase(int unsigned items);
        logic [31:0] x, y, z;
        for (int i = 0; i < items; i++) begin
            if (near_points.size() >= 3 && $urandom_range(2) == 0) begin
                int unsigned k;
                k = $urandom_range(near_points.size() / 3 - 1) * 3;
                x = near_points[k] + $urandom_range(15);
                y = near_points[k + 1] - $urandom_range(15);
                z = near_points[k + 2];
            end else begin
                x = random_coord();
                y = random_coord();
                z = random_coord();
                if (near_points.size() < 300) begin
                    near_points = {near_points, x, y, z};
                end
            end
            send_position(i == 0 || $urandom_range(199) == 0, x, y, z);
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        sender_idle_pct = 14;
        receiver_idle_pct = 48;
        send_position(1, 32'h0, 32'h0, 32'h0);
        send_position(0, 32'h0, 32'h0, 32'h0);
        send_position(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_position(0, 32'h0000_8000, 32'hFFFF_8000, 32'h0000_7FFF);
        send_position(0, 32'h0001_0000, 32'h0000_8000, 32'h0);
        send_position(0, 32'h0000_C000, 32'h0000_8000, 32'h0);
        send_position(1, 32'h0001_0000, 32'h0, 32'h0);
        send_position(0, 32'h0000_FFFF, 32'h0, 32'h0);
        write_recip(32'hFFFF_FFFF);
        send_position(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
        send_position(0, 32'h0001_0000, 32'hFFFF_0000, 32'h5555_AAAA);
        send_position(0, 32'h7FFF_0000, 32'h8001_0000, 32'h0);
        write_recip(32'h0000_0001);
        send_position(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678);
        send_position(0, 32'h0, 32'hFFFF_FFFF, 32'hAAAA_5555);
        write_recip(32'h0);
        send_position(1, 32'h1234_5678, 32'h8765_4321, 32'h7FFF_FFFF);
        send_position(0, 32'h8000_0000, 32'h0, 32'h0000_0001);
        write_recip(32'h0004_0000);
        random_phase(350);

        sender_idle_pct = 48;
        receiver_idle_pct = 14;
        write_recip(32'h0000_4000);
        near_points.delete();
        random_phase(350);

        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        write_recip(32'h0100_0000);
        near_points.delete();
        random_phase(200);
        write_recip($urandom());
        near_points.delete();
        random_phase(200);

        wait_idle();
        if (welds.failures == 0) begin
            $display("vertex_position_welder verification clean");
        end else begin
            $display("vertex_position_welder verification failed");
        end
        $finish;
    end
endmodule
